[rtl/bpfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

   // default sizing of the page pool
   localparam int MAX_PAGES_DEF     = 4096;
   localparam int PAGE_BYTES_DEF    = 4096;
   localparam int MAP_WORD_BITS_DEF = 32;

   // field widths
   localparam int ADDR_W     = 32;
   localparam int PAGES_W    = 13;
   localparam int BASE_W     = PAGES_W + 1;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [ADDR_W-1:0]  POOL_BASE_RST  = 32'h0020_0000;
   localparam logic [PAGES_W-1:0] POOL_PAGES_RST = 13'd4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_PAGES = 1'd1;

   // request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // result codes
   localparam logic [STATUS_W-1:0] RES_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] RES_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] RES_OUTSIDE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RANGE,
      ST_DIV,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESPOND
   } ctl_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic scan_step;
      logic alloc_commit;
      logic full_set;
      logic range_check;
      logic div_step;
      logic free_read;
      logic free_update;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic scan_end;
      logic outside;
      logic rsp_free;
   } ctl_stat_type;

endpackage

`default_nettype wire

[rtl/bpfa_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpfa_req_if;
   import bpfa_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output action, output address, input ready);
   modport sink (input valid, input action, input address, output ready);
endinterface

`default_nettype wire

[rtl/bpfa_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpfa_rsp_if;
   import bpfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   page_address;
   logic [PAGES_W-1:0]  pages_in_use;

   modport source (output valid, output status, output page_address, output pages_in_use,
                   input ready);
   modport sink (input valid, input status, input page_address, input pages_in_use,
                 output ready);
endinterface

`default_nettype wire

[rtl/bpfa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/bpfa_ctl.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpfa_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   input  bpfa_pkg::ctl_stat_type stat,
   output logic                   req_ready,
   output bpfa_pkg::ctl_cmd_type  cmd
);
   import bpfa_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // state register, clearing pass first
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == ACT_FREE) ? ST_RANGE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit || stat.scan_end) state_in = ST_RESPOND;
         end
         ST_RANGE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = stat.outside ? ST_RESPOND : ST_FREE_RD;
         end
         ST_FREE_RD: begin
            state_in = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step    = !(stat.hit || stat.scan_end);
            cmd.alloc_commit = stat.hit;
            cmd.full_set     = stat.scan_end && !stat.hit;
         end
         ST_RANGE: begin
            cmd.range_check = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = !stat.outside;
         end
         ST_FREE_RD: begin
            cmd.free_read = 1'b1;
         end
         ST_FREE_WR: begin
            cmd.free_update = 1'b1;
         end
         ST_RESPOND: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/bpfa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpfa_dp #(
   parameter int MAX_PAGES     = bpfa_pkg::MAX_PAGES_DEF,
   parameter int PAGE_BYTES    = bpfa_pkg::PAGE_BYTES_DEF,
   parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpfa_pkg::ctl_cmd_type             cmd,
   output bpfa_pkg::ctl_stat_type            stat,
   input  logic [bpfa_pkg::ADDR_W-1:0]       req_address,
   input  logic                              csr_write_enable,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bpfa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bpfa_pkg::ADDR_W-1:0]       rsp_page_address,
   output logic [bpfa_pkg::PAGES_W-1:0]      rsp_pages_in_use
);
   import bpfa_pkg::*;

   localparam int MAP_WORDS  = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W      = $clog2(MAP_WORD_BITS);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX32_W    = ADDR_W - PAGE_SHIFT;
   localparam int CALC_W     = ADDR_W + 1;
   // page index to word index by reciprocal multiply, exact for any 13 bit index
   localparam int DIV_SH     = PAGES_W + BIT_W + 1;
   localparam int RECIP      = ((1 << DIV_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int PROD_W     = DIV_SH + WA_W;

   // configuration and derived pool size
   logic [ADDR_W-1:0]  base_ff;
   logic [PAGES_W-1:0] pages_ff;
   logic [PAGES_W-1:0] limit_ff;
   logic [PAGES_W-1:0] limit_in;
   logic [CALC_W-1:0]  room;
   logic [CALC_W-1:0]  fit;
   logic [CALC_W-1:0]  lim;

   // request and result state
   logic [ADDR_W-1:0]   addr_ff;
   logic [STATUS_W-1:0] res_ff;
   logic                alloc_ok_ff;
   logic [PAGES_W-1:0]  alloc_idx_ff;
   logic [PAGES_W-1:0]  count_ff;
   logic [PAGES_W-1:0]  count_in;

   // scan pipeline
   logic [WA_W-1:0]   rd_word_ff;
   logic [BASE_W-1:0] rd_base_ff;
   logic              rd_live;
   logic              chk_pend_ff;
   logic              chk_live_ff;
   logic [BASE_W-1:0] chk_base_ff;
   logic [WA_W-1:0]   chk_word_ff;
   logic [MAP_WORD_BITS-1:0] live_mask;
   logic [MAP_WORD_BITS-1:0] free_bits;
   logic [BIT_W-1:0]  hit_pos;

   // free path
   logic [CALC_W-1:0]  diff;
   logic [IDX32_W-1:0] idx32;
   logic               outside_ff;
   logic               outside_in;
   logic [PAGES_W-1:0] fidx_ff;
   logic [PROD_W-1:0]  prod;
   logic [WA_W-1:0]    q_ff;
   logic [PAGES_W-1:0] fword_base;
   logic [PAGES_W-1:0] fbit_full;
   logic [BIT_W-1:0]   fbit_ff;
   logic               fbit_set;

   // clearing pass
   logic [WA_W-1:0] clr_ff;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_page_ff;
   logic [PAGES_W-1:0]  rsp_count_ff;

   // bitmap memory ports
   logic                     ram_we;
   logic [WA_W-1:0]          ram_waddr;
   logic [MAP_WORD_BITS-1:0] ram_wdata;
   logic                     ram_re;
   logic [WA_W-1:0]          ram_raddr;
   logic [MAP_WORD_BITS-1:0] ram_rdata;

   bpfa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // usable pages: smallest of pool_pages, MAX_PAGES and what fits below 2^32
   always_comb begin
      room = {1'b1, {ADDR_W{1'b0}}} - {1'b0, base_ff};
      fit  = room >> PAGE_SHIFT;
      lim  = CALC_W'(pages_ff);
      if (lim > CALC_W'(MAX_PAGES)) lim = CALC_W'(MAX_PAGES);
      if (lim > fit) lim = fit;
      limit_in = lim[PAGES_W-1:0];
   end

   // free pages of the word under check, lowest first
   always_comb begin
      rd_live = rd_base_ff < {1'b0, limit_ff};
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         live_mask[i] = (chk_base_ff + BASE_W'(i)) < {1'b0, limit_ff};
      end
      free_bits = ~ram_rdata & live_mask;
      hit_pos   = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) hit_pos = BIT_W'(i);
      end
   end

   // free address to page index and range check
   always_comb begin
      diff       = {1'b0, addr_ff} - {1'b0, base_ff};
      idx32      = diff[ADDR_W-1:PAGE_SHIFT];
      outside_in = diff[ADDR_W] || (idx32 >= IDX32_W'(limit_ff));
      prod       = PROD_W'(fidx_ff) * PROD_W'(RECIP);
      fword_base = PAGES_W'(32'(q_ff) * 32'(MAP_WORD_BITS));
      fbit_full  = fidx_ff - fword_base;
      fbit_set   = ram_rdata[fbit_ff];
   end

   // bitmap memory access
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = chk_word_ff;
      ram_wdata = '0;
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
      end else if (cmd.alloc_commit) begin
         ram_we    = 1'b1;
         ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << hit_pos);
      end else if (cmd.free_update) begin
         ram_we    = fbit_set;
         ram_waddr = q_ff;
         ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << fbit_ff);
      end
      ram_re    = (cmd.scan_step && rd_live) || cmd.free_read;
      ram_raddr = cmd.free_read ? q_ff : rd_word_ff;
   end

   // used page count and result handshake
   always_comb begin
      count_in = count_ff;
      if (cmd.alloc_commit) begin
         count_in = count_ff + PAGES_W'(1);
      end else if (cmd.free_update && fbit_set) begin
         count_in = count_ff - PAGES_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // status to the controller
   always_comb begin
      stat.clear_last = (clr_ff == WA_W'(MAP_WORDS - 1));
      stat.hit        = chk_pend_ff && chk_live_ff && (|free_bits);
      stat.scan_end   = chk_pend_ff && !chk_live_ff;
      stat.outside    = outside_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= POOL_BASE_RST;
         pages_ff     <= POOL_PAGES_RST;
         count_ff     <= '0;
         clr_ff       <= '0;
         chk_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_POOL_BASE: begin
                  base_ff <= csr_write_data;
               end
               CSR_POOL_PAGES: begin
                  pages_ff <= csr_write_data[PAGES_W-1:0];
               end
               default: begin
               end
            endcase
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_step) clr_ff <= clr_ff + WA_W'(1);
         if (cmd.accept) begin
            chk_pend_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            chk_pend_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      if (cmd.accept) begin
         addr_ff     <= req_address;
         res_ff      <= RES_DONE;
         alloc_ok_ff <= 1'b0;
         rd_word_ff  <= '0;
         rd_base_ff  <= '0;
      end
      if (cmd.scan_step) begin
         rd_word_ff  <= rd_word_ff + WA_W'(1);
         rd_base_ff  <= rd_base_ff + BASE_W'(MAP_WORD_BITS);
         chk_live_ff <= rd_live;
         chk_base_ff <= rd_base_ff;
         chk_word_ff <= rd_word_ff;
      end
      if (cmd.alloc_commit) begin
         alloc_ok_ff  <= 1'b1;
         alloc_idx_ff <= chk_base_ff[PAGES_W-1:0] + PAGES_W'(hit_pos);
      end
      if (cmd.full_set) res_ff <= RES_FULL;
      if (cmd.range_check) begin
         outside_ff <= outside_in;
         fidx_ff    <= idx32[PAGES_W-1:0];
         if (outside_in) res_ff <= RES_OUTSIDE;
      end
      if (cmd.div_step) q_ff <= prod[DIV_SH +: WA_W];
      if (cmd.free_read) fbit_ff <= fbit_full[BIT_W-1:0];
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_ff;
         rsp_page_ff   <= alloc_ok_ff ?
                          base_ff + (ADDR_W'(alloc_idx_ff) << PAGE_SHIFT) : '0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_page_ff;
   assign rsp_pages_in_use = rsp_count_ff;

`ifndef SYNTH
   // an allocation sets exactly one bit of the word
   a_commit_one_bit: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> $onehot(ram_wdata ^ ram_rdata))
      else $error("allocation changes other than one bitmap bit");

   // a free clears exactly one bit when it writes
   a_free_one_bit: assert property (@(posedge clock) disable iff (reset)
      (cmd.free_update && ram_we) |-> $onehot(ram_wdata ^ ram_rdata))
      else $error("free changes other than one bitmap bit");

   // a result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // the count moves only with a bitmap update
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!cmd.alloc_commit && !cmd.free_update) |=> $stable(count_ff))
      else $error("used count changed without a bitmap update");

   // only a completed allocation carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != RES_DONE) |-> (rsp_page_ff == '0))
      else $error("page address given with a failing status");
`endif

endmodule

`default_nettype wire

[rtl/bitmap_page_frame_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// allocate reads the bitmap a word at a time through the single RAM read port, at most
//   ceil(pool size / MAP_WORD_BITS) words, and reports full when no page is free
// free checks the range, then reads and clears the bit unless the address is outside the pool
// one item in flight; the next item is accepted the cycle after a result is registered
// reset is synchronous; afterwards a clearing pass zeroes all ceil(MAX_PAGES / MAP_WORD_BITS)
//   map words and no item is accepted until it ends
module bitmap_page_frame_allocator_core #(
   parameter int MAX_PAGES     = bpfa_pkg::MAX_PAGES_DEF,
   parameter int PAGE_BYTES    = bpfa_pkg::PAGE_BYTES_DEF,
   parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   bpfa_req_if.sink                        req_ch,
   bpfa_rsp_if.source                      rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import bpfa_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   logic         req_ready;

   // sequencing of each item
   bpfa_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .stat       (stat),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   // bitmap, counters and result register
   bpfa_dp #(
      .MAX_PAGES     (MAX_PAGES),
      .PAGE_BYTES    (PAGE_BYTES),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_address      (req_ch.address),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_page_address (rsp_ch.page_address),
      .rsp_pages_in_use (rsp_ch.pages_in_use)
   );

   assign req_ch.ready = req_ready;

endmodule

`default_nettype wire
